@@ rtl/pbs_pkg.sv @@
`default_nettype none

package pbs_pkg;

  localparam int TASK_COUNT = 16;

  localparam logic FUNC_WAIT   = 1'b0;
  localparam logic FUNC_SIGNAL = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] task_id;
    logic [6:0] task_priority;
  } in_t;

  typedef struct packed {
    logic       acquired;
    logic       blocked;
    logic       full_reject;
    logic       woke_valid;
    logic [3:0] woke_task;
    logic [3:0] waiting_now;
  } out_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic scan;
    logic shift;
    logic finish;
  } pbs_cmd_t;

  typedef struct packed {
    logic is_signal;
    logic list_empty;
    logic scan_done;
    logic shift_done;
  } pbs_sts_t;

endpackage

`default_nettype wire

@@ rtl/pbs_datapath.sv @@
`default_nettype none

module pbs_datapath
  import pbs_pkg::*;
#(
  parameter int LIST_DEPTH = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_t      in_data,
  input  wire pbs_cmd_t cmd,
  output pbs_sts_t      sts,
  output out_t          out_data
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

  logic [3:0]    mem_task [LIST_DEPTH];
  logic [6:0]    mem_prio [LIST_DEPTH];

  in_t           item_r, item_nxt;
  logic          avail_r, avail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rvld_r, rvld_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [3:0]    rd_task_r;
  logic [6:0]    rd_prio_r;
  logic          best_any_r, best_any_nxt;
  logic [CW-1:0] best_idx_r, best_idx_nxt;
  logic [6:0]    best_prio_r, best_prio_nxt;
  logic [3:0]    best_task_r, best_task_nxt;
  logic          acq_r, acq_nxt;
  logic          blk_r, blk_nxt;
  logic          rej_r, rej_nxt;
  logic          wv_r, wv_nxt;
  logic [3:0]    wt_r, wt_nxt;
  out_t          out_r, out_nxt;

  logic          take_new;
  logic [CW-1:0] sel_idx;
  logic [3:0]    sel_task;
  logic [CW-1:0] wr_idx;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  logic [3:0]    mem_wr_task;
  logic [6:0]    mem_wr_prio;
  logic          scan_done;
  logic          shift_done;

  // The earliest entry keeps the lead on equal priority.
  assign take_new   = !best_any_r || (rd_prio_r > best_prio_r);
  assign sel_idx    = take_new ? rd_idx_r : best_idx_r;
  assign sel_task   = take_new ? rd_task_r : best_task_r;
  assign wr_idx     = rd_idx_r - CW'(1);
  assign rd_addr    = idx_r[AW-1:0];
  assign scan_done  = rvld_r && (rd_idx_r == (count_r - CW'(1)));
  assign shift_done = (idx_r == count_r);

  assign sts.is_signal  = (item_r.func == FUNC_SIGNAL);
  assign sts.list_empty = (count_r == '0);
  assign sts.scan_done  = scan_done;
  assign sts.shift_done = shift_done;
  assign out_data       = out_r;

  always_comb begin
    item_nxt      = item_r;
    avail_nxt     = avail_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rvld_nxt      = rvld_r;
    rd_idx_nxt    = rd_idx_r;
    best_any_nxt  = best_any_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_task_nxt = best_task_r;
    acq_nxt       = acq_r;
    blk_nxt       = blk_r;
    rej_nxt       = rej_r;
    wv_nxt        = wv_r;
    wt_nxt        = wt_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wr_addr   = count_r[AW-1:0];
    mem_wr_task   = 4'(item_r.task_id % TASK_COUNT);
    mem_wr_prio   = item_r.task_priority;

    if (cmd.load) begin
      item_nxt = in_data;
    end

    if (cmd.decide) begin
      idx_nxt      = '0;
      rvld_nxt     = 1'b0;
      best_any_nxt = 1'b0;
      acq_nxt      = 1'b0;
      blk_nxt      = 1'b0;
      rej_nxt      = 1'b0;
      wv_nxt       = 1'b0;
      wt_nxt       = '0;
      if (item_r.func == FUNC_WAIT) begin
        if (avail_r) begin
          avail_nxt = 1'b0;
          acq_nxt   = 1'b1;
        end else if (count_r == FULL_COUNT) begin
          rej_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          blk_nxt   = 1'b1;
        end
      end else if (count_r == '0) begin
        avail_nxt = 1'b1;
      end
    end

    if (cmd.scan) begin
      if (rvld_r) begin
        best_any_nxt  = 1'b1;
        best_idx_nxt  = sel_idx;
        best_prio_nxt = take_new ? rd_prio_r : best_prio_r;
        best_task_nxt = sel_task;
      end
      if (idx_r < count_r) begin
        rvld_nxt   = 1'b1;
        rd_idx_nxt = idx_r;
        idx_nxt    = idx_r + CW'(1);
      end else begin
        rvld_nxt = 1'b0;
      end
      if (scan_done) begin
        idx_nxt  = sel_idx + CW'(1);
        rvld_nxt = 1'b0;
        wv_nxt   = 1'b1;
        wt_nxt   = sel_task;
      end
    end

    if (cmd.shift) begin
      if (rvld_r) begin
        mem_we      = 1'b1;
        mem_wr_addr = wr_idx[AW-1:0];
        mem_wr_task = rd_task_r;
        mem_wr_prio = rd_prio_r;
      end
      if (!shift_done) begin
        rvld_nxt   = 1'b1;
        rd_idx_nxt = idx_r;
        idx_nxt    = idx_r + CW'(1);
      end else begin
        rvld_nxt  = 1'b0;
        count_nxt = count_r - CW'(1);
        avail_nxt = 1'b0;
      end
    end

    if (cmd.finish) begin
      out_nxt.acquired    = acq_r;
      out_nxt.blocked     = blk_r;
      out_nxt.full_reject = rej_r;
      out_nxt.woke_valid  = wv_r;
      out_nxt.woke_task   = wt_r;
      out_nxt.waiting_now = 4'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_task[mem_wr_addr] <= mem_wr_task;
      mem_prio[mem_wr_addr] <= mem_wr_prio;
    end
    rd_task_r <= mem_task[rd_addr];
    rd_prio_r <= mem_prio[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= 1'b0;
      count_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      avail_r <= avail_nxt;
      count_r <= count_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_any_r  <= best_any_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_task_r <= best_task_nxt;
    acq_r       <= acq_nxt;
    blk_r       <= blk_nxt;
    rej_r       <= rej_nxt;
    wv_r        <= wv_nxt;
    wt_r        <= wt_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/pbs_ctrl.sv @@
`default_nettype none

module pbs_ctrl
  import pbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire pbs_sts_t sts,
  output pbs_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.is_signal && !sts.list_empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/priority_binary_semaphore.sv @@
// Binary semaphore with a priority-ordered list of waiting tasks.
// The input channel (in_valid, in_ready, in_data) carries one beat per call:
// a wait by a task with its number and priority, or a signal. The output
// channel (out_valid, out_ready, out_data) returns exactly one beat per call,
// in call order.
// For a wait, or a signal on an empty list, the call goes from its decide
// step straight to its final step. A signal with tasks waiting makes two
// passes: one pass reads the list memory one entry per cycle to find the
// first entry of highest priority, and a second pass moves the entries behind
// it up by one, again one read and one write per cycle.
// One call is processed at a time; in_ready is high only when the block is
// idle, which it becomes as the result is issued, so a new call is not taken
// before the previous one has reached its final step. A new call is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the result is held in the output register and the
// next call waits at its final step until the register is free.
// Reset leaves the semaphore unavailable and the list empty, with no result
// pending; no clearing pass is needed.
`default_nettype none

module priority_binary_semaphore
  import pbs_pkg::*;
#(
  parameter int LIST_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  pbs_cmd_t cmd;
  pbs_sts_t sts;

  pbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbs_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/pbs_checker.sv @@
`default_nettype none

module pbs_checker
  import pbs_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A result beat that is not taken stays up and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // At most one outcome is reported per call.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.acquired, out_data.blocked,
                            out_data.full_reject, out_data.woke_valid}))
    else $error("more than one outcome flag set");

  // A task number is shown only when a task was woken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.woke_valid |-> out_data.woke_task == 4'd0)
    else $error("woke_task set without a woken task");

  // The semaphore can be free only while nobody waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.acquired |-> out_data.waiting_now == 4'd0)
    else $error("acquired while tasks are waiting");

  // Calls are processed one at a time, so an accepted beat closes the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

endmodule

bind priority_binary_semaphore pbs_checker u_pbs_checker (.*);

`default_nettype wire
